### rtl/glms_pkg.sv
// Package for the grid local minimum block: register indexes, field widths
// and reset values for the top level; the checker shares the result widths.
// No dependencies.
`default_nettype none

package glms_pkg;

    // Configuration port
    localparam int CFG_BITS       = 8;
    localparam int CFG_INDEX_BITS = 1;

    localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_HEIGHT = 1'b1;

    localparam logic [CFG_BITS-1:0] SIZE_RESET = 8'd100;

    // Result fields
    localparam int SUM_BITS     = 18;
    localparam int COUNT_BITS   = 15;
    localparam int M_TDATA_BITS = ((SUM_BITS + COUNT_BITS + 7) / 8) * 8;

endpackage

`default_nettype wire

### rtl/grid_local_minimum_sum.sv
// The result of a frame is registered and shown on the master side in the cycle
// after its last cell is accepted. Throughput: one cell per cycle; the only stall is a
// frame's last cell meeting a result that is still waiting. The line buffers are
// read ahead at the column of the next request. Reset is synchronous and active
// low: sizes return to 100, counters and sums to zero; the line buffers are not
// cleared and hold nothing valid until written.
`default_nettype none

module grid_local_minimum_sum #(
    parameter int MAX_WIDTH   = 128,
    parameter int MAX_HEIGHT  = 128,
    parameter int HEIGHT_BITS = 4,
    localparam int S_TDATA_BITS = ((HEIGHT_BITS + 7) / 8) * 8
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,

    input  wire logic                                 cfg_wr_en,
    input  wire logic [glms_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [glms_pkg::CFG_BITS-1:0]        cfg_wdata,

    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [S_TDATA_BITS-1:0]              s_tdata,   // cell_height

    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic [glms_pkg::M_TDATA_BITS-1:0]         m_tdata    // risk_sum, minima_count
);

    localparam int COL_BITS = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_BITS = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int SUM_BITS   = glms_pkg::SUM_BITS;
    localparam int COUNT_BITS = glms_pkg::COUNT_BITS;

    // Line buffers, indexed by column
    logic [HEIGHT_BITS-1:0] row_above_mem [MAX_WIDTH];
    logic [HEIGHT_BITS-1:0] two_rows_mem  [MAX_WIDTH];

    logic [glms_pkg::CFG_BITS-1:0] grid_width_reg;
    logic [glms_pkg::CFG_BITS-1:0] grid_height_reg;
    logic [COL_BITS-1:0]           col_reg;
    logic [ROW_BITS-1:0]           row_reg;
    logic [HEIGHT_BITS-1:0]        left_reg;      // cell at column - 1 of this row
    logic [HEIGHT_BITS-1:0]        left2_reg;     // cell at column - 2 of this row
    logic [HEIGHT_BITS-1:0]        above_d1_reg;  // cell above the previous one
    logic [HEIGHT_BITS-1:0]        above_rd_reg;  // row above, this column
    logic [HEIGHT_BITS-1:0]        right_rd_reg;  // row above, next column
    logic [HEIGHT_BITS-1:0]        up_rd_reg;     // two rows above, this column
    logic [SUM_BITS-1:0]           sum_reg;
    logic [COUNT_BITS-1:0]         count_reg;
    logic                          m_valid_reg;
    logic [glms_pkg::M_TDATA_BITS-1:0] m_data_reg;

    logic [COL_BITS-1:0]    width_last;
    logic [ROW_BITS-1:0]    height_last;
    logic                   last_col;
    logic                   last_row;
    logic                   frame_end;
    logic                   accept;
    logic [HEIGHT_BITS-1:0] cur;
    logic [COL_BITS-1:0]    col_next;
    logic [ROW_BITS-1:0]    row_next;
    logic [COL_BITS-1:0]    rd_col;
    logic [COL_BITS-1:0]    rd_col_p1;
    logic                   row_ge1;
    logic                   row_ge2;
    logic                   col_ge1;
    logic                   col_ge2;
    logic                   judge_above;
    logic                   judge_left;
    logic                   judge_cur;
    logic [SUM_BITS-1:0]    sum_next;
    logic [COUNT_BITS-1:0]  count_next;

    function automatic logic lower_than(input logic [HEIGHT_BITS-1:0] centre,
                                        input logic                   present,
                                        input logic [HEIGHT_BITS-1:0] other);
        return !present || (other > centre);
    endfunction

    // Sizes of zero act as one, sizes beyond the buffers act as the maximum.
    always_comb begin
        if (grid_width_reg == '0) begin
            width_last = '0;
        end else if (32'(grid_width_reg) > MAX_WIDTH) begin
            width_last = COL_BITS'(MAX_WIDTH - 1);
        end else begin
            width_last = COL_BITS'(grid_width_reg - 1'b1);
        end
        if (grid_height_reg == '0) begin
            height_last = '0;
        end else if (32'(grid_height_reg) > MAX_HEIGHT) begin
            height_last = ROW_BITS'(MAX_HEIGHT - 1);
        end else begin
            height_last = ROW_BITS'(grid_height_reg - 1'b1);
        end
    end

    assign last_col  = col_reg >= width_last;
    assign last_row  = row_reg >= height_last;
    assign frame_end = last_col && last_row;

    // Only a frame's last cell produces a result, so only that one waits for
    // the output register to free up.
    assign s_tready = aresetn && !(m_valid_reg && !m_tready && frame_end);
    assign accept   = s_tvalid && s_tready;
    assign cur      = s_tdata[HEIGHT_BITS-1:0];

    assign col_next = last_col ? '0 : col_reg + 1'b1;
    always_comb begin
        if (!last_col) begin
            row_next = row_reg;
        end else if (last_row) begin
            row_next = '0;
        end else begin
            row_next = row_reg + 1'b1;
        end
    end

    // The buffers are read at the column of the next request, so the data
    // sits in the read registers when that request arrives.
    assign rd_col    = accept ? col_next : col_reg;
    assign rd_col_p1 = rd_col + 1'b1;

    always_ff @(posedge aclk) begin
        if (accept) begin
            row_above_mem[col_reg] <= cur;
            two_rows_mem[col_reg]  <= above_rd_reg;
        end
        if (accept && rd_col == col_reg) begin
            above_rd_reg <= cur;
            up_rd_reg    <= above_rd_reg;
        end else begin
            above_rd_reg <= row_above_mem[rd_col];
            up_rd_reg    <= two_rows_mem[rd_col];
        end
        if (accept && rd_col_p1 == col_reg) begin
            right_rd_reg <= cur;
        end else begin
            right_rd_reg <= row_above_mem[rd_col_p1];
        end
    end

    assign row_ge1 = row_reg != '0;
    assign row_ge2 = row_reg > ROW_BITS'(1);
    assign col_ge1 = col_reg != '0;
    assign col_ge2 = col_reg > COL_BITS'(1);

    // Cell above the arriving one: all its neighbours are now known.
    assign judge_above = row_ge1
        && lower_than(above_rd_reg, row_ge2, up_rd_reg)
        && lower_than(above_rd_reg, 1'b1, cur)
        && lower_than(above_rd_reg, col_ge1, above_d1_reg)
        && lower_than(above_rd_reg, !last_col, right_rd_reg);

    // On the bottom row the cell to the left is decided by its right neighbour.
    assign judge_left = last_row && col_ge1
        && lower_than(left_reg, row_ge1, above_d1_reg)
        && lower_than(left_reg, col_ge2, left2_reg)
        && lower_than(left_reg, 1'b1, cur);

    // The frame's last cell has no neighbour still to come.
    assign judge_cur = frame_end
        && lower_than(cur, row_ge1, above_rd_reg)
        && lower_than(cur, col_ge1, left_reg);

    always_comb begin
        sum_next = sum_reg;
        if (judge_above) begin
            sum_next = sum_next + SUM_BITS'(above_rd_reg) + SUM_BITS'(1);
        end
        if (judge_left) begin
            sum_next = sum_next + SUM_BITS'(left_reg) + SUM_BITS'(1);
        end
        if (judge_cur) begin
            sum_next = sum_next + SUM_BITS'(cur) + SUM_BITS'(1);
        end
        count_next = count_reg + COUNT_BITS'(judge_above) + COUNT_BITS'(judge_left)
                     + COUNT_BITS'(judge_cur);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_width_reg  <= glms_pkg::SIZE_RESET;
            grid_height_reg <= glms_pkg::SIZE_RESET;
            col_reg         <= '0;
            row_reg         <= '0;
            left_reg        <= '0;
            sum_reg         <= '0;
            count_reg       <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    glms_pkg::REG_GRID_WIDTH:  grid_width_reg  <= cfg_wdata;
                    glms_pkg::REG_GRID_HEIGHT: grid_height_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (accept) begin
                col_reg      <= col_next;
                row_reg      <= row_next;
                left_reg     <= cur;
                left2_reg    <= left_reg;
                above_d1_reg <= above_rd_reg;
                if (frame_end) begin
                    sum_reg     <= '0;
                    count_reg   <= '0;
                    m_valid_reg <= 1'b1;
                    m_data_reg  <= glms_pkg::M_TDATA_BITS'({count_next, sum_next});
                end else begin
                    sum_reg   <= sum_next;
                    count_reg <= count_next;
                    if (m_tready) begin
                        m_valid_reg <= 1'b0;
                    end
                end
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

`default_nettype wire

### rtl/glms_checker.sv
// Port-level checks for grid_local_minimum_sum, attached by the bind below.
// Depends on glms_pkg for the result field widths.
`default_nettype none

module glms_checker (
    input wire logic                                 aclk,
    input wire logic                                 aresetn,
    input wire logic                                 s_tvalid,
    input wire logic                                 s_tready,
    input wire logic                                 m_tvalid,
    input wire logic                                 m_tready,
    input wire logic [glms_pkg::M_TDATA_BITS-1:0]    m_tdata
);

    localparam int SUM_BITS   = glms_pkg::SUM_BITS;
    localparam int COUNT_BITS = glms_pkg::COUNT_BITS;

    // Reset empties the output register.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result still offered after reset");

    // A waiting result is held until taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("waiting result changed or dropped");

    // A result only ever follows an accepted request.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready))
        else $error("result appeared without an accepted request");

    // With no minima in a frame there is nothing to sum.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[SUM_BITS+COUNT_BITS-1:SUM_BITS] == '0
        |-> m_tdata[SUM_BITS-1:0] == '0)
        else $error("non-zero risk sum with zero minima");

endmodule

bind grid_local_minimum_sum glms_checker u_glms_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
